### design/fast_inverse_square_root_macros.svh
// ----------------------------------------------------------------------------
// fast_inverse_square_root_macros.svh
// Assertion macros used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQUARE_ROOT_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_MACROS_SVH

// same-cycle implication
`define FISR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FISR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Constants, class flags and the shared normalize/round helpers.
// ----------------------------------------------------------------------------
package fisr_pkg;

    localparam logic [31:0] MAGIC        = 32'h5f3759df;
    localparam logic [31:0] FP_ONE       = 32'h3f800000;
    localparam logic [31:0] FP_HALF      = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HLF = 32'h3fc00000;
    localparam logic [31:0] FP_QNAN      = 32'h7fc00000;

    localparam int UNIT_DEPTH = 3;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } fisr_class_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        end
        return n;
    endfunction

    // m has its leading one at bit 47, er is the biased exponent for it
    function automatic logic [31:0] round_pack(input logic sign, input logic [47:0] m,
                                               input logic signed [10:0] er);
        logic signed [10:0] t;
        logic [5:0]         sh;
        logic [7:0]         ef;
        logic [47:0]        sm;
        logic               sticky;
        logic               inc;
        logic [30:0]        rs;
        logic [31:0]        res;
        if (er <= 11'sd0) begin
            t  = 11'sd1 - er;
            sh = (t > 11'sd48) ? 6'd48 : t[5:0];
            ef = 8'd0;
        end
        else begin
            t  = 11'sd0;
            sh = 6'd0;
            ef = er[7:0];
        end
        sm     = m >> sh;
        sticky = |(m & ~({48{1'b1}} << sh));
        inc    = sm[23] & ((|sm[22:0]) | sticky | sm[24]);
        rs     = {ef, sm[46:24]} + {30'd0, inc};
        if (er >= 11'sd255)
            res = {sign, 8'hFF, 23'd0};
        else
            res = {sign, rs};
        return res;
    endfunction

endpackage

### design/fisr_delay.sv
// ----------------------------------------------------------------------------
// fisr_delay
// Enabled shift line that keeps side data aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module fisr_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [D];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < D; i++)
                line_reg[i] <= '0;
        end
        else if (en) begin
            line_reg[0] <= d;
            for (int i = 1; i < D; i++)
                line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[D-1];

endmodule

### design/fisr_norm.sv
// ----------------------------------------------------------------------------
// fisr_norm
// Two-stage normalize, round-to-nearest-even and pack for binary32.
// ----------------------------------------------------------------------------
module fisr_norm (
    input  logic                       clk,
    input  logic                       en,
    input  fisr_pkg::fisr_class_t      cls,
    input  logic [47:0]                m,
    input  logic signed [10:0]         e,
    output logic [31:0]                p
);
    import fisr_pkg::*;

    fisr_class_t        cls_reg;
    logic [47:0]        m_reg;
    logic signed [10:0] er_reg;
    logic [31:0]        p_reg;
    logic [5:0]         lz;
    logic [31:0]        p_next;

    assign lz = lzc48(m);

    always_ff @(posedge clk) begin
        if (en) begin
            cls_reg <= cls;
            m_reg   <= m << lz;
            er_reg  <= e - 11'(lz);
        end
    end

    always_comb begin
        if (cls_reg.nan)
            p_next = FP_QNAN;
        else if (cls_reg.inf)
            p_next = {cls_reg.sign, 8'hFF, 23'd0};
        else if (cls_reg.zero)
            p_next = {cls_reg.sign, 31'd0};
        else
            p_next = round_pack(cls_reg.sign, m_reg, er_reg);
    end

    always_ff @(posedge clk) begin
        if (en)
            p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

### design/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul
// Pipelined binary32 multiplier: mantissa product, then normalize and round.
// ----------------------------------------------------------------------------
module fisr_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    import fisr_pkg::*;

    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    fisr_class_t        cls_next, cls_reg;
    logic [47:0]        prod_reg;
    logic signed [10:0] e_reg;

    always_comb begin
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        nan_a  = (&a[30:23]) & (|a[22:0]);
        nan_b  = (&b[30:23]) & (|b[22:0]);
        inf_a  = (&a[30:23]) & ~(|a[22:0]);
        inf_b  = (&b[30:23]) & ~(|b[22:0]);
        zero_a = ~(|a[30:0]);
        zero_b = ~(|b[30:0]);
        cls_next.nan  = nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
        cls_next.inf  = inf_a | inf_b;
        cls_next.zero = zero_a | zero_b;
        cls_next.sign = a[31] ^ b[31];
    end

    always_ff @(posedge clk) begin
        if (en) begin
            cls_reg  <= cls_next;
            prod_reg <= ma * mb;
            e_reg    <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
        end
    end

    fisr_norm u_norm (
        .clk (clk),
        .en  (en),
        .cls (cls_reg),
        .m   (prod_reg),
        .e   (e_reg),
        .p   (p)
    );

endmodule

### design/fisr_fsub.sv
// ----------------------------------------------------------------------------
// fisr_fsub
// Pipelined binary32 subtractor a - b: align and add, then normalize and round.
// ----------------------------------------------------------------------------
module fisr_fsub (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    import fisr_pkg::*;

    logic [31:0]        bn;
    logic               nan_a, nan_b, inf_a, inf_b;
    logic               a_big;
    logic [31:0]        big, sml;
    logic [7:0]         e_big, e_sml, dexp;
    logic [4:0]         dcap;
    logic [26:0]        m_big, m_sml, al, al_st;
    logic               st;
    logic [27:0]        sum;
    fisr_class_t        cls_next, cls_reg;
    logic [27:0]        sum_reg;
    logic [7:0]         e_reg;

    always_comb begin
        bn     = {~b[31], b[30:0]};
        nan_a  = (&a[30:23]) & (|a[22:0]);
        nan_b  = (&bn[30:23]) & (|bn[22:0]);
        inf_a  = (&a[30:23]) & ~(|a[22:0]);
        inf_b  = (&bn[30:23]) & ~(|bn[22:0]);
        a_big  = a[30:0] >= bn[30:0];
        big    = a_big ? a : bn;
        sml    = a_big ? bn : a;
        e_big  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_big  = {big[30:23] != 8'd0, big[22:0], 3'd0};
        m_sml  = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        dexp   = e_big - e_sml;
        dcap   = (dexp > 8'd27) ? 5'd28 : dexp[4:0];
        al     = m_sml >> dcap;
        st     = |(m_sml & ~({27{1'b1}} << dcap));
        al_st  = {al[26:1], al[0] | st};
        if (big[31] != sml[31])
            sum = {1'b0, m_big} - {1'b0, al_st};
        else
            sum = {1'b0, m_big} + {1'b0, al_st};
        cls_next.nan  = nan_a | nan_b | (inf_a & inf_b & (a[31] != bn[31]));
        cls_next.inf  = inf_a | inf_b;
        cls_next.zero = (sum == 28'd0);
        if (inf_a | inf_b)
            cls_next.sign = inf_a ? a[31] : bn[31];
        else if (sum == 28'd0)
            cls_next.sign = big[31] & sml[31];
        else
            cls_next.sign = big[31];
    end

    always_ff @(posedge clk) begin
        if (en) begin
            cls_reg <= cls_next;
            sum_reg <= sum;
            e_reg   <= e_big;
        end
    end

    fisr_norm u_norm (
        .clk (clk),
        .en  (en),
        .cls (cls_reg),
        .m   ({sum_reg, 20'd0}),
        .e   ($signed({3'd0, e_reg}) + 11'sd1),
        .p   (p)
    );

endmodule

### design/fast_inverse_square_root.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Throughput: one word per cycle while the output is not stalled; six
// 3-stage float units in series set depth.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
`include "fast_inverse_square_root_macros.svh"

module fast_inverse_square_root (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits
);
    import fisr_pkg::*;

    logic        en;
    logic        v0_reg;
    logic        mode0_reg;
    logic [31:0] x0_reg, y0_reg;
    logic [31:0] y0_d3, y0_d6, y0_d12;
    logic [31:0] half, p1, p2, dd, y1, r;
    logic [32:0] side_d15;
    logic [31:0] sel;
    logic        v_d18;
    logic        out_valid_reg;
    logic [31:0] result_reg, result_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mode0_reg <= action;
            x0_reg    <= value_bits;
            y0_reg    <= MAGIC - {value_bits[31], value_bits[31:1]};
        end
    end

    fisr_fmul u_half (.clk(clk), .en(en), .a(x0_reg), .b(FP_HALF), .p(half));

    fisr_delay #(.W(32), .D(UNIT_DEPTH)) u_y0_a (
        .clk(clk), .rst_n(rst_n), .en(en), .d(y0_reg), .q(y0_d3));

    fisr_fmul u_p1 (.clk(clk), .en(en), .a(half), .b(y0_d3), .p(p1));

    fisr_delay #(.W(32), .D(UNIT_DEPTH)) u_y0_b (
        .clk(clk), .rst_n(rst_n), .en(en), .d(y0_d3), .q(y0_d6));

    fisr_fmul u_p2 (.clk(clk), .en(en), .a(p1), .b(y0_d6), .p(p2));

    fisr_fsub u_d (.clk(clk), .en(en), .a(FP_THREE_HLF), .b(p2), .p(dd));

    fisr_delay #(.W(32), .D(2 * UNIT_DEPTH)) u_y0_c (
        .clk(clk), .rst_n(rst_n), .en(en), .d(y0_d6), .q(y0_d12));

    fisr_fmul u_y1 (.clk(clk), .en(en), .a(y0_d12), .b(dd), .p(y1));

    fisr_delay #(.W(33), .D(5 * UNIT_DEPTH)) u_side (
        .clk(clk), .rst_n(rst_n), .en(en), .d({mode0_reg, x0_reg}), .q(side_d15));

    assign sel = side_d15[32] ? side_d15[31:0] : FP_ONE;

    fisr_fmul u_r (.clk(clk), .en(en), .a(y1), .b(sel), .p(r));

    fisr_delay #(.W(1), .D(6 * UNIT_DEPTH)) u_vld (
        .clk(clk), .rst_n(rst_n), .en(en), .d(v0_reg), .q(v_d18));

    // canonical quiet NaN on the way out
    assign result_next = ((&r[30:23]) && (|r[22:0])) ? FP_QNAN : r;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_d18;
    end

    always_ff @(posedge clk) begin
        if (en)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

    `FISR_ASSERT_NOW(a_nan_canonical, out_valid && (&result_bits[30:23]) && (|result_bits[22:0]), result_bits == FP_QNAN, "non-canonical NaN on output")
    `FISR_ASSERT_NEXT(a_stall_hold, !en, $stable(y0_reg) && $stable(v0_reg), "pipeline moved during stall")
    `FISR_ASSERT_NOW(a_rise_enabled, $rose(out_valid_reg), $past(en), "output valid rose without advance")

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams binary32 words and a mode bit through fast_inverse_square_root.
// A bit-exact integer model of the estimate and its Newton step predicts
// each result, which is compared in order against the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import fisr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [31:0] value_bits = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_bits;

    logic [31:0] expected_roots[$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    fast_inverse_square_root dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .value_bits(value_bits),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_bits(result_bits)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---- binary32 arithmetic, round to nearest even, denormals kept ----

    function automatic bit is_nan(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic bit is_zero(logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // value = m * 2^e
    function automatic void unpack(input logic [31:0] a, output logic [79:0] m, output int e);
        if (a[30:23] == 8'd0)
        begin
            m = {57'd0, a[22:0]};
            e = -149;
        end
        else
        begin
            m = {56'd0, 1'b1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] round_to_single(bit s, logic [79:0] m, int e);
        int          msb;
        int          sh;
        int          be;
        logic [79:0] q;
        logic [79:0] rem;
        logic [79:0] half;
        msb = 0;
        for (int i = 0; i < 80; i++)
            if (m[i])
                msb = i;
        sh = msb - 23;
        if (-149 - e > sh)
            sh = -149 - e;
        if (sh > 80)
            return {s, 31'd0};
        if (sh > 0)
        begin
            q    = (sh == 80) ? 80'd0 : (m >> sh);
            rem  = m & ((80'd1 << sh) - 80'd1);
            half = 80'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 80'd1;
        end
        else
            q = m << (-sh);
        e = e + sh;
        if (q >= (80'd1 << 24))
        begin
            q = q >> 1;
            e = e + 1;
        end
        if (q < (80'd1 << 23))
            return {s, 8'd0, q[22:0]};
        be = e + 150;
        if (be >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, be[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        logic [79:0] ma;
        logic [79:0] mb;
        int          ea;
        int          eb;
        bit          s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b))
            return FP_QNAN;
        if (is_inf(a) || is_inf(b))
            return (is_zero(a) || is_zero(b)) ? FP_QNAN : {s, 8'hFF, 23'd0};
        if (is_zero(a) || is_zero(b))
            return {s, 31'd0};
        unpack(a, ma, ea);
        unpack(b, mb, eb);
        return round_to_single(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [79:0] ma;
        logic [79:0] mb;
        logic [79:0] tm;
        logic [79:0] m;
        int          ea;
        int          eb;
        int          te;
        int          emin;
        bit          sa;
        bit          sb;
        bit          ts;
        bit          s;
        if (is_nan(a) || is_nan(b))
            return FP_QNAN;
        if (is_inf(a) && is_inf(b))
            return (a[31] != b[31]) ? FP_QNAN : a;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        if (is_zero(a) && is_zero(b))
            return {a[31] & b[31], 31'd0};
        if (is_zero(a))
            return b;
        if (is_zero(b))
            return a;
        unpack(a, ma, ea);
        unpack(b, mb, eb);
        sa = a[31];
        sb = b[31];
        if (eb > ea)
        begin
            tm = ma; ma = mb; mb = tm;
            te = ea; ea = eb; eb = te;
            ts = sa; sa = sb; sb = ts;
        end
        emin = (eb > ea - 40) ? eb : ea - 40;
        ma = ma << (ea - emin);
        if (eb < emin)
            mb = (mb >> (emin - eb)) | 80'(|(mb & ((80'd1 << (emin - eb)) - 80'd1)));
        else
            mb = mb << (eb - emin);
        if (sa == sb)
        begin
            m = ma + mb;
            s = sa;
        end
        else if (ma >= mb)
        begin
            m = ma - mb;
            s = sa;
        end
        else
        begin
            m = mb - ma;
            s = sb;
        end
        if (m == 80'd0)
            return 32'd0;
        return round_to_single(s, m, emin);
    endfunction

    function automatic logic [31:0] predict_root(logic act, logic [31:0] x);
        logic [31:0] y0;
        logic [31:0] p2;
        logic [31:0] y1;
        logic [31:0] r;
        y0 = MAGIC - {x[31], x[31:1]};
        p2 = f32_mul(f32_mul(f32_mul(x, FP_HALF), y0), y0);
        y1 = f32_mul(y0, f32_add(FP_THREE_HLF, {~p2[31], p2[30:0]}));
        r  = act ? f32_mul(y1, x) : y1;
        return is_nan(r) ? FP_QNAN : r;
    endfunction

    // ---- stimulus ----

    task automatic send_word(logic act, logic [31:0] x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        action     <= act;
        value_bits <= x;
        do
            @(posedge clk);
        while (!in_ready);
        expected_roots.push_back(predict_root(act, x));
    endtask

    task automatic test_special_values();
        logic [31:0] specials[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                      32'hff80_0000, 32'h7fc0_0000, 32'hff80_0001,
                                      32'h0000_0001, 32'h007f_ffff, 32'h0080_0000,
                                      32'h7f7f_ffff, 32'h3f80_0000, 32'hbf80_0000};
        foreach (specials[i])
        begin
            send_word(1'b0, specials[i]);
            send_word(1'b1, specials[i]);
        end
    endtask

    task automatic test_random_words(int count);
        logic [31:0] x;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    x = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
                6:
                    x = $urandom;
                7:
                    x = {1'($urandom), 8'd0, 23'($urandom >> $urandom_range(0, 22))};
                8:
                    x = {1'($urandom), 8'hFF,
                         ($urandom_range(0, 1) == 0) ? 23'd0 : 23'($urandom)};
                default:
                    x = {1'b1, 8'($urandom_range(1, 254)), 23'($urandom)};
            endcase
            send_word(1'($urandom), x);
        end
    endtask

    // ---- receiver stall pattern ----

    int stall_phase = 0;
    always @(posedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 400;
        if (stall_phase < 100)
            out_ready <= 1'b1;
        else if (stall_phase < 250)
            out_ready <= ($urandom_range(0, 2) != 0);
        else if (stall_phase < 300)
            out_ready <= ((stall_phase % 25) > 18);
        else
            out_ready <= ($urandom_range(0, 1) == 0);
    end

    // ---- result check ----

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, result_bits);
                fail_count++;
            end
            else
            begin
                if (result_bits !== expected_roots[0])
                begin
                    $display("%0t: result_bits expected %h actual %h",
                             $time, expected_roots[0], result_bits);
                    fail_count++;
                end
                void'(expected_roots.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fast_inverse_square_root verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_random_words(650);
        in_valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("fast_inverse_square_root verification clean");
        else
            $display("fast_inverse_square_root verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/fisr_pkg.sv
design/fisr_delay.sv
design/fisr_norm.sv
design/fisr_fmul.sv
design/fisr_fsub.sv
design/fast_inverse_square_root.sv
verif/tb.sv
